// ===== src/fuzzy_brake_pressure_controller_macros.svh =====
// Assertion macros shared by the fuzzy brake pressure controller RTL.
// No dependencies; included by the files that carry assertions.
`ifndef FUZZY_BRAKE_PRESSURE_CONTROLLER_MACROS_SVH
`define FUZZY_BRAKE_PRESSURE_CONTROLLER_MACROS_SVH

`ifndef SYNTHESIS
`define FBPC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("fbpc assertion failed");
`define FBPC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fbpc implication failed");
`else
`define FBPC_ASSERT(label, clk, rst_n, prop)
`define FBPC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== src/fbpc_pkg.sv =====
// Package of the fuzzy brake pressure controller: widths, constants,
// output sample tables and constant-division helpers. No dependencies.
`default_nettype none

package fbpc_pkg;

    localparam int FRAC_BITS     = 8;
    localparam int OUTPUT_POINTS = 101;
    localparam int ONE           = 1 << FRAC_BITS;
    localparam int FULL_SCALE    = 100 * ONE;

    localparam int IN_W   = 15;
    localparam int MU_W   = FRAC_BITS + 1;
    localparam int STR_W  = 14;
    localparam int X_W    = 15;
    localparam int Q_W    = 15;
    localparam int PROD_W = STR_W + X_W;
    localparam int TREE_LVLS = $clog2(OUTPUT_POINTS);
    localparam int NUM_W  = PROD_W + TREE_LVLS;
    localparam int DEN_W  = STR_W + TREE_LVLS;

    // floor(a / d) = (a * ceil(2^SH / d)) >> SH, exact for a < 2^15
    localparam int RECIP_W  = 17;
    localparam int RECIP_SH = 21;
    localparam logic [RECIP_W-1:0] RECIP_20 = RECIP_W'(((1 << RECIP_SH) + 19) / 20);
    localparam logic [RECIP_W-1:0] RECIP_50 = RECIP_W'(((1 << RECIP_SH) + 49) / 50);
    localparam logic [RECIP_W-1:0] RECIP_60 = RECIP_W'(((1 << RECIP_SH) + 59) / 60);

    localparam int STR_GAIN = 30;

    typedef struct packed {
        logic [STR_W-1:0] apply_str;
        logic [STR_W-1:0] release_str;
    } side_t;

    function automatic logic [MU_W-1:0] scale_div(input logic [IN_W-1:0] a,
                                                  input logic [RECIP_W-1:0] m);
        logic [IN_W+RECIP_W-1:0] prod;
        prod = {{RECIP_W{1'b0}}, a} * {{IN_W{1'b0}}, m};
        return MU_W'(prod >> RECIP_SH);
    endfunction

    function automatic logic [X_W-1:0] point_x(input int k);
        longint t;
        t = (longint'(FULL_SCALE) * longint'(k)) / (OUTPUT_POINTS - 1);
        return X_W'(t);
    endfunction

    function automatic logic [STR_W-1:0] point_rise(input int k);
        longint t;
        t = (3 * longint'(point_x(k))) / 10;
        return STR_W'(t);
    endfunction

    function automatic logic [STR_W-1:0] point_fall(input int k);
        longint t;
        longint top;
        top = 300 * longint'(ONE);
        t   = 3 * longint'(point_x(k));
        return (top > t) ? STR_W'((top - t) / 10) : '0;
    endfunction

    function automatic int tree_cnt(input int lv);
        return (OUTPUT_POINTS + (1 << lv) - 1) >> lv;
    endfunction

endpackage

`default_nettype wire

// ===== src/fbpc_div.sv =====
// Pipelined restoring divider for the centroid, one quotient bit per stage,
// with rounding and zero-area detect. Depends on fbpc_pkg.
`default_nettype none

module fbpc_div import fbpc_pkg::*; (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             en,
    input  wire logic             in_valid,
    input  wire logic [NUM_W-1:0] in_num,
    input  wire logic [DEN_W-1:0] in_den,
    input  wire side_t            in_side,
    output logic                  out_valid,
    output logic [Q_W-1:0]        out_quo,
    output logic                  out_nonzero,
    output side_t                 out_side
);

    logic [NUM_W:0]   rem_reg  [0:Q_W];
    logic [Q_W-1:0]   quo_reg  [0:Q_W];
    logic [DEN_W-1:0] den_reg  [0:Q_W];
    side_t            side_reg [0:Q_W];
    logic             nz_reg   [0:Q_W];
    logic             vld_reg  [0:Q_W];

    logic [NUM_W:0] shifted_den [1:Q_W];

    always_comb begin
        for (int j = 1; j <= Q_W; j++) begin
            shifted_den[j] = (NUM_W+1)'({den_reg[j-1], {(Q_W){1'b0}}} >> j);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j <= Q_W; j++) begin
                vld_reg[j] <= 1'b0;
            end
        end else if (en) begin
            vld_reg[0] <= in_valid;
            for (int j = 1; j <= Q_W; j++) begin
                vld_reg[j] <= vld_reg[j-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= (NUM_W+1)'(in_num) + (NUM_W+1)'(in_den >> 1);
            quo_reg[0]  <= '0;
            den_reg[0]  <= in_den;
            side_reg[0] <= in_side;
            nz_reg[0]   <= (in_den != '0);
            for (int j = 1; j <= Q_W; j++) begin
                den_reg[j]  <= den_reg[j-1];
                side_reg[j] <= side_reg[j-1];
                nz_reg[j]   <= nz_reg[j-1];
                if (rem_reg[j-1] >= shifted_den[j]) begin
                    rem_reg[j] <= rem_reg[j-1] - shifted_den[j];
                    quo_reg[j] <= quo_reg[j-1] | (Q_W'(1) << (Q_W - j));
                end else begin
                    rem_reg[j] <= rem_reg[j-1];
                    quo_reg[j] <= quo_reg[j-1];
                end
            end
        end
    end

    assign out_valid   = vld_reg[Q_W];
    assign out_nonzero = nz_reg[Q_W];
    assign out_quo     = nz_reg[Q_W] ? quo_reg[Q_W] : '0;
    assign out_side    = side_reg[Q_W];

endmodule

`default_nettype wire

// ===== src/fuzzy_brake_pressure_controller.sv =====
// Fuzzy brake pressure controller: takes one transaction per clock with
// backpressure; the pipeline is 5 input/inference stages, a registered adder
// tree of ceil(log2(OUTPUT_POINTS)) levels (7 for 101 points) and a 16-stage
// centroid divider. The divider, one quotient bit per stage, sets the depth.
// Depends on fbpc_pkg, fbpc_div and the macros header.
`default_nettype none

`include "fuzzy_brake_pressure_controller_macros.svh"

module fuzzy_brake_pressure_controller import fbpc_pkg::*; (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [IN_W-1:0]  s_brake_pressure,
    input  wire logic [IN_W-1:0]  s_car_speed,
    input  wire logic [IN_W-1:0]  s_wheel_speed,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic [Q_W-1:0]        m_final_pressure,
    output logic                  m_result_valid,
    output logic [STR_W-1:0]      m_apply_strength,
    output logic [STR_W-1:0]      m_release_strength
);

    localparam int P = OUTPUT_POINTS;

    logic adv;
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    // stage 1: saturated inputs
    logic            v1_reg;
    logic [IN_W-1:0] p_reg, c_reg, w_reg;

    // stage 2: memberships
    logic            v2_reg;
    logic [MU_W-1:0] p_low_reg, p_med_reg, p_high_reg, c_high_reg, w_low_reg, w_high_reg;
    logic [MU_W-1:0] p_low_next, p_med_next, p_high_next, c_high_next, w_low_next, w_high_next;
    logic [IN_W-1:0] p_dev;

    // stage 3: strengths
    logic  v3_reg;
    side_t str_reg;
    side_t str_next;
    logic [MU_W-1:0] r2, r3;

    // stage 4: aggregate per point
    logic             v4_reg;
    side_t            side4_reg;
    logic [STR_W-1:0] agg_reg [0:P-1];

    // tree: level 0 holds products and aggregates
    logic [NUM_W-1:0] num_tree_reg [0:TREE_LVLS][0:P-1];
    logic [DEN_W-1:0] den_tree_reg [0:TREE_LVLS][0:P-1];
    logic             vt_reg       [0:TREE_LVLS];
    side_t            side_t_reg   [0:TREE_LVLS];

    function automatic logic [IN_W-1:0] clamp_in(input logic [IN_W-1:0] v);
        return (v > IN_W'(FULL_SCALE)) ? IN_W'(FULL_SCALE) : v;
    endfunction

    always_comb begin
        p_dev = (p_reg > IN_W'(50 * ONE)) ? p_reg - IN_W'(50 * ONE) : IN_W'(50 * ONE) - p_reg;
        p_low_next  = (p_reg < IN_W'(50 * ONE)) ?
                      scale_div(IN_W'(50 * ONE) - p_reg, RECIP_50) : '0;
        p_med_next  = (p_dev < IN_W'(20 * ONE)) ?
                      scale_div(IN_W'(20 * ONE) - p_dev, RECIP_20) : '0;
        p_high_next = (p_reg > IN_W'(50 * ONE)) ?
                      scale_div(p_reg - IN_W'(50 * ONE), RECIP_50) : '0;
        c_high_next = (c_reg > IN_W'(40 * ONE)) ?
                      scale_div(c_reg - IN_W'(40 * ONE), RECIP_60) : '0;
        w_low_next  = (w_reg < IN_W'(60 * ONE)) ?
                      scale_div(IN_W'(60 * ONE) - w_reg, RECIP_60) : '0;
        w_high_next = (w_reg > IN_W'(40 * ONE)) ?
                      scale_div(w_reg - IN_W'(40 * ONE), RECIP_60) : '0;
    end

    always_comb begin
        r2 = (c_high_reg < w_high_reg) ? c_high_reg : w_high_reg;
        r2 = (p_high_reg < r2) ? p_high_reg : r2;
        r3 = (c_high_reg < w_low_reg) ? c_high_reg : w_low_reg;
        r3 = (p_high_reg < r3) ? p_high_reg : r3;
        str_next.apply_str   = STR_W'(((MU_W+1)'(p_med_reg) + (MU_W+1)'(r2)) * STR_W'(STR_GAIN));
        str_next.release_str = STR_W'(((MU_W+1)'(r3) + (MU_W+1)'(p_low_reg)) * STR_W'(STR_GAIN));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            for (int l = 0; l <= TREE_LVLS; l++) begin
                vt_reg[l] <= 1'b0;
            end
        end else if (adv) begin
            v1_reg    <= s_valid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            vt_reg[0] <= v4_reg;
            for (int l = 1; l <= TREE_LVLS; l++) begin
                vt_reg[l] <= vt_reg[l-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p_reg <= clamp_in(s_brake_pressure);
            c_reg <= clamp_in(s_car_speed);
            w_reg <= clamp_in(s_wheel_speed);

            p_low_reg  <= p_low_next;
            p_med_reg  <= p_med_next;
            p_high_reg <= p_high_next;
            c_high_reg <= c_high_next;
            w_low_reg  <= w_low_next;
            w_high_reg <= w_high_next;

            str_reg <= str_next;

            side4_reg <= str_reg;
            for (int k = 0; k < P; k++) begin
                agg_reg[k] <= ((point_rise(k) < str_reg.apply_str) ?
                               point_rise(k) : str_reg.apply_str) >
                              ((point_fall(k) < str_reg.release_str) ?
                               point_fall(k) : str_reg.release_str) ?
                              ((point_rise(k) < str_reg.apply_str) ?
                               point_rise(k) : str_reg.apply_str) :
                              ((point_fall(k) < str_reg.release_str) ?
                               point_fall(k) : str_reg.release_str);
            end

            side_t_reg[0] <= side4_reg;
            for (int k = 0; k < P; k++) begin
                num_tree_reg[0][k] <= NUM_W'(PROD_W'(agg_reg[k]) * PROD_W'(point_x(k)));
                den_tree_reg[0][k] <= DEN_W'(agg_reg[k]);
            end

            for (int l = 1; l <= TREE_LVLS; l++) begin
                side_t_reg[l] <= side_t_reg[l-1];
                for (int i = 0; i < P; i++) begin
                    if (i < tree_cnt(l)) begin
                        if (2 * i + 1 < tree_cnt(l - 1)) begin
                            num_tree_reg[l][i] <= num_tree_reg[l-1][2*i] +
                                                  num_tree_reg[l-1][2*i+1];
                            den_tree_reg[l][i] <= den_tree_reg[l-1][2*i] +
                                                  den_tree_reg[l-1][2*i+1];
                        end else begin
                            num_tree_reg[l][i] <= num_tree_reg[l-1][2*i];
                            den_tree_reg[l][i] <= den_tree_reg[l-1][2*i];
                        end
                    end else begin
                        num_tree_reg[l][i] <= '0;
                        den_tree_reg[l][i] <= '0;
                    end
                end
            end
        end
    end

    side_t out_side;

    fbpc_div u_div (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (adv),
        .in_valid    (vt_reg[TREE_LVLS]),
        .in_num      (num_tree_reg[TREE_LVLS][0]),
        .in_den      (den_tree_reg[TREE_LVLS][0]),
        .in_side     (side_t_reg[TREE_LVLS]),
        .out_valid   (m_valid),
        .out_quo     (m_final_pressure),
        .out_nonzero (m_result_valid),
        .out_side    (out_side)
    );

    assign m_apply_strength   = out_side.apply_str;
    assign m_release_strength = out_side.release_str;

    `FBPC_ASSERT_IMPL(a_zero_area_clears, aclk, aresetn,
        m_valid && !m_result_valid, m_final_pressure == '0)
    `FBPC_ASSERT_IMPL(a_no_strength_no_area, aclk, aresetn,
        m_valid && m_apply_strength == '0 && m_release_strength == '0, !m_result_valid)
    `FBPC_ASSERT_IMPL(a_centroid_in_range, aclk, aresetn,
        m_valid, m_final_pressure <= Q_W'(FULL_SCALE))
    `FBPC_ASSERT(a_strength_in_range, aclk, aresetn,
        m_valid |-> (m_apply_strength <= STR_W'(2 * ONE * STR_GAIN)))

endmodule

`default_nettype wire

// ===== verif/fbpc_checker.sv =====
// Checker for the fuzzy brake pressure controller: watches both channels,
// computes the expected centroid and strengths per transaction and compares.
// Depends on fbpc_pkg for widths.
`timescale 1ns / 100ps

module fbpc_checker import fbpc_pkg::*; (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    input  wire logic             s_ready,
    input  wire logic [IN_W-1:0]  s_brake_pressure,
    input  wire logic [IN_W-1:0]  s_car_speed,
    input  wire logic [IN_W-1:0]  s_wheel_speed,
    input  wire logic             m_valid,
    input  wire logic             m_ready,
    input  wire logic [Q_W-1:0]   m_final_pressure,
    input  wire logic             m_result_valid,
    input  wire logic [STR_W-1:0] m_apply_strength,
    input  wire logic [STR_W-1:0] m_release_strength,
    output int                    fail_count,
    output int                    pending,
    output int                    results_seen,
    output int                    zero_area_seen
);

    typedef struct packed {
        logic [Q_W-1:0]   pressure;
        logic             valid;
        logic [STR_W-1:0] apply_str;
        logic [STR_W-1:0] release_str;
    } braking_t;

    braking_t expected_q[$];

    function automatic longint sat_in(input logic [IN_W-1:0] v);
        return (v > FULL_SCALE) ? FULL_SCALE : longint'(v);
    endfunction

    function automatic longint ramp(input longint a, input longint b, input longint d);
        return (a > b) ? (a - b) / d : 0;
    endfunction

    function automatic longint lmin(input longint a, input longint b);
        return (a < b) ? a : b;
    endfunction

    function automatic braking_t infer_braking(input logic [IN_W-1:0] bp,
                                               input logic [IN_W-1:0] cs,
                                               input logic [IN_W-1:0] ws);
        longint p, c, w, p_dev, r1, r2, r3, r4, apply_s, release_s;
        longint num, den, x, fa, fl, agg;
        braking_t r;
        p = sat_in(bp);
        c = sat_in(cs);
        w = sat_in(ws);
        p_dev = (p > 50 * ONE) ? p - 50 * ONE : 50 * ONE - p;
        r1 = ramp(20 * ONE, p_dev, 20);
        r2 = lmin(ramp(p, 50 * ONE, 50), lmin(ramp(c, 40 * ONE, 60), ramp(w, 40 * ONE, 60)));
        r3 = lmin(ramp(p, 50 * ONE, 50), lmin(ramp(c, 40 * ONE, 60), ramp(60 * ONE, w, 60)));
        r4 = ramp(50 * ONE, p, 50);
        apply_s = (r1 + r2) * 30;
        release_s = (r3 + r4) * 30;
        num = 0;
        den = 0;
        for (int k = 0; k < OUTPUT_POINTS; k++) begin
            x = (longint'(FULL_SCALE) * k) / (OUTPUT_POINTS - 1);
            fa = lmin((3 * x) / 10, apply_s);
            fl = lmin(release_s, ramp(300 * ONE, 3 * x, 10));
            agg = (fa > fl) ? fa : fl;
            num += agg * x;
            den += agg;
        end
        r.pressure = (den != 0) ? Q_W'((num + den / 2) / den) : '0;
        r.valid = (den != 0);
        r.apply_str = STR_W'(apply_s);
        r.release_str = STR_W'(release_s);
        return r;
    endfunction

    always @(posedge aclk) begin
        braking_t e;
        int errs;
        errs = 0;
        if (!aresetn) begin
            expected_q.delete();
            fail_count <= 0;
            results_seen <= 0;
            zero_area_seen <= 0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen <= results_seen + 1;
                if (expected_q.size() == 0) begin
                    $error("result transaction with nothing expected");
                    errs = errs + 1;
                end else begin
                    e = expected_q.pop_front();
                    if (!e.valid) zero_area_seen <= zero_area_seen + 1;
                    if (m_final_pressure !== e.pressure) begin
                        $error("final_pressure exp %0d got %0d", e.pressure, m_final_pressure);
                        errs = errs + 1;
                    end
                    if (m_result_valid !== e.valid) begin
                        $error("result_valid exp %0d got %0d", e.valid, m_result_valid);
                        errs = errs + 1;
                    end
                    if (m_apply_strength !== e.apply_str) begin
                        $error("apply_strength exp %0d got %0d", e.apply_str,
                               m_apply_strength);
                        errs = errs + 1;
                    end
                    if (m_release_strength !== e.release_str) begin
                        $error("release_strength exp %0d got %0d", e.release_str,
                               m_release_strength);
                        errs = errs + 1;
                    end
                end
            end
            if (s_valid && s_ready)
                expected_q.push_back(infer_braking(s_brake_pressure, s_car_speed,
                                                   s_wheel_speed));
            fail_count <= fail_count + errs;
        end
    end

    always @(posedge aclk) pending <= expected_q.size();

endmodule

// ===== verif/testbench.sv =====
// Testbench top for the fuzzy brake pressure controller: drives sensor
// transactions under varied idling and gives the verdict.
// Depends on fbpc_pkg, the RTL and fbpc_checker.
`timescale 1ns / 100ps

module testbench;
    import fbpc_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;

    logic             aclk;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    logic [IN_W-1:0]  s_brake_pressure;
    logic [IN_W-1:0]  s_car_speed;
    logic [IN_W-1:0]  s_wheel_speed;
    logic             m_valid;
    logic             m_ready;
    logic [Q_W-1:0]   m_final_pressure;
    logic             m_result_valid;
    logic [STR_W-1:0] m_apply_strength;
    logic [STR_W-1:0] m_release_strength;
    int               fail_count;
    int               pending;
    int               results_seen;
    int               zero_area_seen;
    int               send_idle_pct;
    int               recv_stall_pct;
    int               idle_cycles;
    logic             timed_out;

    fuzzy_brake_pressure_controller DUT (.*);

    fbpc_checker u_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // receiver back-pressure
    always @(posedge aclk) begin
        if (!aresetn)
            m_ready <= 1'b0;
        else
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog on accepted transactions
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
            timed_out <= 1'b1;
            $display("watchdog expired, %0d results still expected", pending);
            $display("[fuzzy_brake_pressure_controller] ERROR");
            $finish;
        end
    end

    function automatic logic [IN_W-1:0] pick_sensor();
        case ($urandom_range(9))
            0: return IN_W'($urandom_range(32767));
            1: return IN_W'($urandom_range(FULL_SCALE + 8, FULL_SCALE - 8));
            2: return IN_W'($urandom_range(50 * ONE + 600, 50 * ONE - 600));
            3: return IN_W'($urandom_range(40 * ONE + 600, 40 * ONE - 600));
            default: return IN_W'($urandom_range(FULL_SCALE));
        endcase
    endfunction

    task automatic send_sample(input logic [IN_W-1:0] bp, input logic [IN_W-1:0] cs,
                               input logic [IN_W-1:0] ws);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_brake_pressure <= bp;
        s_car_speed <= cs;
        s_wheel_speed <= ws;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    initial begin
        logic [IN_W-1:0] corner[8];
        corner = '{0, 1, 40 * ONE, 50 * ONE, 60 * ONE, FULL_SCALE, FULL_SCALE + 1, 15'h7FFF};
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_brake_pressure = '0;
        s_car_speed = '0;
        s_wheel_speed = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        idle_cycles = 0;
        timed_out = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed corners, including zero area (full pressure, car speed low)
        for (int i = 0; i < 8; i++)
            send_sample(corner[i], corner[(i + 3) % 8], corner[(i + 5) % 8]);
        send_sample(30 * ONE, 0, 0);
        send_sample(70 * ONE, FULL_SCALE, FULL_SCALE);
        send_sample(70 * ONE, FULL_SCALE, 0);
        send_sample(FULL_SCALE, 30 * ONE, 50 * ONE);
        send_sample(15'h5555, 15'h2AAA, 15'h7FFF);
        send_sample(15'h2AAA, 15'h5555, 15'h0000);

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                1: begin send_idle_pct = 53; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 53; end
                3: begin send_idle_pct = 10; recv_stall_pct = 10; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            for (int n = 0; n < 180; n++)
                send_sample(pick_sensor(), pick_sensor(), pick_sensor());
        end
        s_valid <= 1'b0;

        recv_stall_pct = 0;
        @(posedge aclk);
        while (pending != 0 || u_checker.expected_q.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        $display("covered %0d results, %0d with zero area, under five idling mixes",
                 results_seen, zero_area_seen);
        if (fail_count == 0)
            $display("[fuzzy_brake_pressure_controller] OK");
        else
            $display("[fuzzy_brake_pressure_controller] ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/fbpc_pkg.sv
src/fbpc_div.sv
src/fuzzy_brake_pressure_controller.sv
verif/fbpc_checker.sv
verif/testbench.sv
